>>> src/crb_pkg.sv
package crb_pkg;

  localparam int CoefW = 12;
  localparam int InW = 16;
  localparam int MulW = 2 * CoefW;
  localparam int RedW = 26;
  localparam int RecipW = 15;
  localparam int EstW = RedW + RecipW;
  localparam int DataW = 32;
  localparam int AddrW = 3;

  localparam logic [CoefW-1:0] ModQ = CoefW'(3457);
  localparam logic [CoefW-1:0] HalfQ = CoefW'(1728);
  localparam logic [RecipW-1:0] Recip = RecipW'((64'd1 << RedW) / 3457);
  // shifts any signed 16-bit coefficient into the positive range
  localparam logic [RedW-1:0] InOffset = RedW'(10 * 3457);

  localparam logic [CoefW-1:0] Z0FirstReset = CoefW'(9);
  localparam logic [CoefW-1:0] Z0SecondReset = CoefW'(3);

  localparam int StMul = 2;
  localparam int StSum = 3;
  localparam int StRedT = 4;
  localparam int StZ = 6;
  localparam int StAdd = 7;
  localparam int StRedF = 8;
  localparam int StOut = 10;
  localparam int NumStages = StOut + 1;

  typedef enum logic [0:0] {
    RegZ0First  = 1'b0,
    RegZ0Second = 1'b1
  } reg_idx_e;

  typedef logic [CoefW-1:0] res_t;
  typedef logic [RedW-1:0] wide_t;

  typedef struct packed {
    res_t z0_first;
    res_t z0_second;
  } cfg_t;

  typedef struct packed {
    wide_t t0;
    wide_t t1;
    wide_t e0;
    wide_t e1;
    wide_t e2;
  } sums_t;

  function automatic wide_t lift(logic [InW-1:0] v);
    wide_t w;
    w = {{(RedW-InW){v[InW-1]}}, v} + InOffset;
    return w;
  endfunction

endpackage

>>> src/crb_in_if.sv
interface crb_in_if import crb_pkg::*; ();
  logic valid;
  logic ready;
  logic mode;
  logic half;
  logic signed [InW-1:0] a_coef0;
  logic signed [InW-1:0] a_coef1;
  logic signed [InW-1:0] a_coef2;
  logic signed [InW-1:0] b_coef0;
  logic signed [InW-1:0] b_coef1;
  logic signed [InW-1:0] b_coef2;
  logic signed [InW-1:0] add_coef0;
  logic signed [InW-1:0] add_coef1;
  logic signed [InW-1:0] add_coef2;

  modport source (
    output valid, mode, half, a_coef0, a_coef1, a_coef2, b_coef0, b_coef1, b_coef2,
    output add_coef0, add_coef1, add_coef2,
    input ready
  );
  modport sink (
    input valid, mode, half, a_coef0, a_coef1, a_coef2, b_coef0, b_coef1, b_coef2,
    input add_coef0, add_coef1, add_coef2,
    output ready
  );
endinterface

>>> src/crb_out_if.sv
interface crb_out_if import crb_pkg::*; ();
  logic valid;
  logic ready;
  logic signed [CoefW-1:0] res_coef0;
  logic signed [CoefW-1:0] res_coef1;
  logic signed [CoefW-1:0] res_coef2;

  modport source (
    output valid, res_coef0, res_coef1, res_coef2,
    input ready
  );
  modport sink (
    input valid, res_coef0, res_coef1, res_coef2,
    output ready
  );
endinterface

>>> src/cubic_ring_basemul.sv
// an input beat passes through every register stage in order before its result leaves the output register
// throughput: one beat per cycle while the output is not stalled, eleven register stages
// the depth comes from three two-step modular reductions (inputs, z0 terms, final sums)
// a stalled output holds its stage; earlier stages keep filling any empty slots
// reset clears all valid bits and loads z0 registers with 9 and 3; data registers are not reset
module cubic_ring_basemul import crb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  crb_in_if.sink           inp_i,
  crb_out_if.source        res_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  cfg_t                  cfg;
  logic [NumStages-1:0]  valid_q;
  logic [NumStages-1:0]  en;
  logic [StOut-1:0]      mode_q;
  logic [StZ-1:0]        half_q;
  logic [2:0][InW-1:0]   a_in, b_in, c_in;
  res_t [2:0]            a_r, b_r, c_r;
  res_t [2:0]            c_q [StMul:StOut-1];
  sums_t                 sums;
  wide_t [2:0]           e_q [StRedT:StZ];
  res_t                  t0_r, t1_r;
  res_t                  z0_sel;
  logic [MulW-1:0]       m0_q, m1_q;
  wide_t [2:0]           f_q;
  res_t [2:0]            f_r;
  res_t [2:0]            out_d, out_q;
  logic [CoefW:0]        acc [3];

  crb_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // stage enables, a stage moves when empty or when the next one moves
  always_comb begin
    en[NumStages-1] = !valid_q[NumStages-1] || res_o.ready;
    for (int i = NumStages - 2; i >= 0; i--) begin
      en[i] = !valid_q[i] || en[i+1];
    end
  end

  assign inp_i.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) begin
        valid_q[0] <= inp_i.valid;
      end
      for (int i = 1; i < NumStages; i++) begin
        if (en[i]) begin
          valid_q[i] <= valid_q[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      mode_q[0] <= inp_i.mode;
      half_q[0] <= inp_i.half;
    end
    for (int i = 1; i < StOut; i++) begin
      if (en[i]) begin
        mode_q[i] <= mode_q[i-1];
      end
    end
    for (int i = 1; i < StZ; i++) begin
      if (en[i]) begin
        half_q[i] <= half_q[i-1];
      end
    end
  end

  assign a_in = {inp_i.a_coef2, inp_i.a_coef1, inp_i.a_coef0};
  assign b_in = {inp_i.b_coef2, inp_i.b_coef1, inp_i.b_coef0};
  assign c_in = {inp_i.add_coef2, inp_i.add_coef1, inp_i.add_coef0};

  for (genvar k = 0; k < 3; k++) begin : g_in_red
    crb_reduce u_red_a (
      .clk_i    (clk_i),
      .en_est_i (en[0]),
      .en_fix_i (en[1]),
      .x_i      (lift(a_in[k])),
      .r_o      (a_r[k])
    );
    crb_reduce u_red_b (
      .clk_i    (clk_i),
      .en_est_i (en[0]),
      .en_fix_i (en[1]),
      .x_i      (lift(b_in[k])),
      .r_o      (b_r[k])
    );
    crb_reduce u_red_c (
      .clk_i    (clk_i),
      .en_est_i (en[0]),
      .en_fix_i (en[1]),
      .x_i      (lift(c_in[k])),
      .r_o      (c_r[k])
    );
  end

  crb_prod u_prod (
    .clk_i    (clk_i),
    .en_mul_i (en[StMul]),
    .en_sum_i (en[StSum]),
    .a_i      (a_r),
    .b_i      (b_r),
    .sums_o   (sums)
  );

  always_ff @(posedge clk_i) begin
    if (en[StMul]) begin
      c_q[StMul] <= c_r;
    end
    for (int i = StMul + 1; i < StOut; i++) begin
      if (en[i]) begin
        c_q[i] <= c_q[i-1];
      end
    end
    if (en[StRedT]) begin
      e_q[StRedT] <= {sums.e2, sums.e1, sums.e0};
    end
    for (int i = StRedT + 1; i <= StZ; i++) begin
      if (en[i]) begin
        e_q[i] <= e_q[i-1];
      end
    end
  end

  crb_reduce u_red_t0 (
    .clk_i    (clk_i),
    .en_est_i (en[StRedT]),
    .en_fix_i (en[StRedT+1]),
    .x_i      (sums.t0),
    .r_o      (t0_r)
  );

  crb_reduce u_red_t1 (
    .clk_i    (clk_i),
    .en_est_i (en[StRedT]),
    .en_fix_i (en[StRedT+1]),
    .x_i      (sums.t1),
    .r_o      (t1_r)
  );

  assign z0_sel = half_q[StZ-1] ? cfg.z0_second : cfg.z0_first;

  always_ff @(posedge clk_i) begin
    if (en[StZ]) begin
      m0_q <= MulW'(t0_r) * MulW'(z0_sel);
      m1_q <= MulW'(t1_r) * MulW'(z0_sel);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[StAdd]) begin
      f_q[0] <= e_q[StZ][0] + wide_t'(m0_q);
      f_q[1] <= e_q[StZ][1] + wide_t'(m1_q);
      f_q[2] <= e_q[StZ][2];
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_out_red
    crb_reduce u_red_f (
      .clk_i    (clk_i),
      .en_est_i (en[StRedF]),
      .en_fix_i (en[StRedF+1]),
      .x_i      (f_q[k]),
      .r_o      (f_r[k])
    );
  end

  // optional addend, then map to the centered range
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      acc[k] = {1'b0, f_r[k]};
      if (mode_q[StOut-1]) begin
        acc[k] = acc[k] + {1'b0, c_q[StOut-1][k]};
        if (acc[k] >= {1'b0, ModQ}) begin
          acc[k] = acc[k] - {1'b0, ModQ};
        end
      end
      if (acc[k] > {1'b0, HalfQ}) begin
        acc[k] = acc[k] - {1'b0, ModQ};
      end
      out_d[k] = acc[k][CoefW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[StOut]) begin
      out_q <= out_d;
    end
  end

  assign res_o.valid     = valid_q[StOut];
  assign res_o.res_coef0 = out_q[0];
  assign res_o.res_coef1 = out_q[1];
  assign res_o.res_coef2 = out_q[2];

  a_in_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (inp_i.valid && inp_i.ready) |=> valid_q[0])
    else $error("accepted beat did not enter the first stage");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (&valid_q && !res_o.ready) |-> !inp_i.ready)
    else $error("input taken while every stage is full and output stalled");

  a_centered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.res_coef0 >= -12'sd1728 && res_o.res_coef0 <= 12'sd1728 &&
                     res_o.res_coef1 >= -12'sd1728 && res_o.res_coef1 <= 12'sd1728 &&
                     res_o.res_coef2 >= -12'sd1728 && res_o.res_coef2 <= 12'sd1728))
    else $error("result coefficient outside the centered range");

endmodule

>>> src/crb_cfg.sv
module crb_cfg import crb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx   = reg_idx_e'(paddr[AddrW-1]);
  assign wr_en = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        RegZ0First:  cfg_d.z0_first = pwdata[CoefW-1:0];
        RegZ0Second: cfg_d.z0_second = pwdata[CoefW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegZ0First:  prdata = DataW'(cfg_q.z0_first);
      RegZ0Second: prdata = DataW'(cfg_q.z0_second);
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.z0_first  <= Z0FirstReset;
      cfg_q.z0_second <= Z0SecondReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> src/crb_reduce.sv
module crb_reduce import crb_pkg::*; (
  input  logic  clk_i,
  input  logic  en_est_i,
  input  logic  en_fix_i,
  input  wide_t x_i,
  output res_t  r_o
);

  logic [EstW-1:0]   est;
  wide_t             x_q;
  logic [RecipW-1:0] quo_q;
  wide_t             sub;
  wide_t             diff;
  logic [CoefW:0]    rem;
  res_t              r_d, r_q;

  // quotient estimate, low by at most one
  assign est = EstW'(x_i) * EstW'(Recip);

  always_ff @(posedge clk_i) begin
    if (en_est_i) begin
      x_q   <= x_i;
      quo_q <= est[EstW-1:RedW];
    end
  end

  assign sub  = wide_t'(quo_q) * wide_t'(ModQ);
  assign diff = x_q - sub;
  assign rem  = diff[CoefW:0];
  assign r_d  = (rem >= {1'b0, ModQ}) ? CoefW'(rem - {1'b0, ModQ}) : rem[CoefW-1:0];

  always_ff @(posedge clk_i) begin
    if (en_fix_i) begin
      r_q <= r_d;
    end
  end

  assign r_o = r_q;

endmodule

>>> src/crb_prod.sv
module crb_prod import crb_pkg::*; (
  input  logic       clk_i,
  input  logic       en_mul_i,
  input  logic       en_sum_i,
  input  res_t [2:0] a_i,
  input  res_t [2:0] b_i,
  output sums_t      sums_o
);

  logic [MulW-1:0] p_q [3][3];
  sums_t           sums_d, sums_q;

  always_ff @(posedge clk_i) begin
    if (en_mul_i) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          p_q[i][j] <= MulW'(a_i[i]) * MulW'(b_i[j]);
        end
      end
    end
  end

  always_comb begin
    sums_d.t0 = wide_t'(p_q[1][2]) + wide_t'(p_q[2][1]);
    sums_d.t1 = wide_t'(p_q[2][2]);
    sums_d.e0 = wide_t'(p_q[0][0]);
    sums_d.e1 = wide_t'(p_q[0][1]) + wide_t'(p_q[1][0]);
    sums_d.e2 = wide_t'(p_q[0][2]) + wide_t'(p_q[1][1]) + wide_t'(p_q[2][0]);
  end

  always_ff @(posedge clk_i) begin
    if (en_sum_i) begin
      sums_q <= sums_d;
    end
  end

  assign sums_o = sums_q;

endmodule
